[hw/rtl/lbs_pkg.sv]
// shared types and constants for the bounded lifo stack
package lbs_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = 7;
    localparam int WORD_W      = 32;
    localparam int GROUP       = 8;
    localparam int NUM_GROUPS  = STACK_DEPTH / GROUP;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_BOTTOM = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BADPOS    = 2'd3
    } status_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

    localparam word_t ERR_WORD = -32'sd1;

endpackage

[hw/rtl/lbs_cell.sv]
// one stack cell: holds one entry and shifts with its neighbors
module lbs_cell (
    input  logic           aclk,
    input  lbs_pkg::shift_t shift,
    input  lbs_pkg::word_t from_above,
    input  lbs_pkg::word_t from_below,
    input  logic           sel,
    output lbs_pkg::word_t entry,
    output lbs_pkg::word_t tap
);
    import lbs_pkg::*;

    word_t entry_reg;
    word_t entry_next;

    // push moves everything one place deeper, pop one place up
    always_comb begin
        entry_next = entry_reg;
        if (shift.push) begin
            entry_next = from_above;
        end else if (shift.pop) begin
            entry_next = from_below;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    // gated copy for the peek or-tree
    assign tap   = sel ? entry_reg : '0;

endmodule

[hw/rtl/bounded_lifo_stack_unit.sv]
// top level of the bounded lifo stack: cell row, control and result register
//
// A bounded LIFO stack of signed 32-bit words built as a row of STACK_DEPTH
// cells. Cell 0 always holds the top entry: a push shifts every cell one
// place deeper, a pop shifts every cell one place up, so push and pop touch
// no address logic. A peek at position p selects cell p-1 through a gated
// or-tree that is registered once after the groups of eight cells; the
// bottom entry is kept in a register of its own. Every request gives one
// result: it passes the s1 stage register (for a peek, the peek tree
// register) and then the output register. A new request is taken once
// the previous one has left the tree stage, and the output register lets
// a new request in while a finished result still waits. The capacity
// register (reset 64) is written through the cfg channel; the user must
// do so only while the block is idle, the block does not enforce it;
// 0 acts as 1, and values above the depth act as the depth. Errors return
// -1 with overflow, underflow or bad-position status.
module bounded_lifo_stack_unit (
    input  logic             aclk,
    input  logic             aresetn,
    // capacity write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  lbs_pkg::cnt_t    cfg_data,
    // request channel
    input  logic             s_valid,
    output logic             s_ready,
    input  lbs_pkg::kind_t   s_kind,
    input  lbs_pkg::word_t   s_push_value,
    input  lbs_pkg::cnt_t    s_position,
    // result channel
    output logic             m_valid,
    input  logic             m_ready,
    output lbs_pkg::word_t   m_data,
    output lbs_pkg::status_t m_status,
    output lbs_pkg::cnt_t    m_occupancy,
    output logic             m_empty_flag,
    output logic             m_full_flag
);
    import lbs_pkg::*;

    // control state
    cnt_t    cap_reg,   cap_next;
    cnt_t    count_reg, count_next;
    logic    s1_valid_reg, s1_valid_next;
    logic    m_valid_reg,  m_valid_next;

    // payload state
    word_t   bottom_reg,  bottom_next;
    status_t s1_status_reg, s1_status_next;
    logic    s1_tree_reg,   s1_tree_next;
    word_t   s1_word_reg,   s1_word_next;
    word_t   grp_reg [NUM_GROUPS];
    word_t   grp_next [NUM_GROUPS];
    word_t   m_data_reg,  m_data_next;
    status_t m_status_reg, m_status_next;
    cnt_t    m_occ_reg,   m_occ_next;
    logic    m_empty_reg, m_empty_next;
    logic    m_full_reg,  m_full_next;

    // cell row
    shift_t  shift;
    word_t   cell_entry [STACK_DEPTH];
    word_t   cell_tap   [STACK_DEPTH];
    logic    cell_sel   [STACK_DEPTH];

    logic    req_acc;
    logic    out_load;
    cnt_t    eff_cap;
    logic    full_now;
    logic    empty_now;
    word_t   tree_word;
    word_t   s1_result;

    // cfg always taken; the user must make writes arrive only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;
    assign s_ready   = !s1_valid_reg;
    assign req_acc   = s_valid && s_ready;
    assign out_load  = s1_valid_reg && (!m_valid_reg || m_ready);

    // clamp capacity into 1..depth
    always_comb begin
        eff_cap = cap_reg;
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_reg > CNT_W'(STACK_DEPTH)) begin
            eff_cap = CNT_W'(STACK_DEPTH);
        end
    end

    assign full_now  = (count_reg >= eff_cap);
    assign empty_now = (count_reg == '0);

    // cells: peek select compares the request position to the cell index
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        word_t above;
        word_t below;
        if (i == 0) begin : g_top
            assign above = s_push_value;
        end else begin : g_mid_a
            assign above = cell_entry[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_last
            assign below = '0;
        end else begin : g_mid_b
            assign below = cell_entry[i+1];
        end
        assign cell_sel[i] = (s_position == CNT_W'(i + 1));

        lbs_cell u_cell (
            .aclk       (aclk),
            .shift      (shift),
            .from_above (above),
            .from_below (below),
            .sel        (cell_sel[i]),
            .entry      (cell_entry[i]),
            .tap        (cell_tap[i])
        );
    end

    // first level of the peek tree: or of each group of eight taps
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                grp_next[g] = grp_next[g] | cell_tap[g*GROUP + k];
            end
        end
    end

    // second level, from registered groups
    always_comb begin
        tree_word = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            tree_word = tree_word | grp_reg[g];
        end
    end

    // request decode: shift command, new count, status and early data
    always_comb begin
        shift          = '0;
        count_next     = count_reg;
        bottom_next    = bottom_reg;
        s1_valid_next  = s1_valid_reg;
        s1_status_next = s1_status_reg;
        s1_tree_next   = s1_tree_reg;
        s1_word_next   = s1_word_reg;
        cap_next       = cap_reg;

        if (cfg_valid && cfg_ready) begin
            cap_next = cfg_data;
        end

        if (out_load) begin
            s1_valid_next = 1'b0;
        end

        if (req_acc) begin
            s1_valid_next  = 1'b1;
            s1_status_next = ST_OK;
            s1_tree_next   = 1'b0;
            s1_word_next   = ERR_WORD;
            case (s_kind)
                KIND_PUSH: begin
                    if (full_now) begin
                        s1_status_next = ST_OVERFLOW;
                    end else begin
                        shift.push   = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                        s1_word_next = '0;
                        // first entry is also the bottom
                        if (empty_now) begin
                            bottom_next = s_push_value;
                        end
                    end
                end
                KIND_POP: begin
                    if (empty_now) begin
                        s1_status_next = ST_UNDERFLOW;
                    end else begin
                        shift.pop    = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                        s1_word_next = cell_entry[0];
                    end
                end
                KIND_PEEK: begin
                    if (s_position == '0 || s_position > count_reg) begin
                        s1_status_next = ST_BADPOS;
                    end else begin
                        s1_tree_next = 1'b1;
                    end
                end
                KIND_BOTTOM: begin
                    if (empty_now) begin
                        s1_status_next = ST_UNDERFLOW;
                    end else begin
                        s1_word_next = bottom_reg;
                    end
                end
                default: begin
                    s1_status_next = ST_UNDERFLOW;
                end
            endcase
        end
    end

    // result word: error word wins, then tree or early data
    always_comb begin
        if (s1_status_reg != ST_OK) begin
            s1_result = ERR_WORD;
        end else if (s1_tree_reg) begin
            s1_result = tree_word;
        end else begin
            s1_result = s1_word_reg;
        end
    end

    // output register; count already holds the post-request value here
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_occ_next    = m_occ_reg;
        m_empty_next  = m_empty_reg;
        m_full_next   = m_full_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_data_next   = s1_result;
            m_status_next = s1_status_reg;
            m_occ_next    = count_reg;
            m_empty_next  = empty_now;
            m_full_next   = full_now;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= CNT_W'(STACK_DEPTH);
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cap_reg      <= cap_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        bottom_reg    <= bottom_next;
        s1_status_reg <= s1_status_next;
        s1_tree_reg   <= s1_tree_next;
        s1_word_reg   <= s1_word_next;
        if (req_acc) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                grp_reg[g] <= grp_next[g];
            end
        end
        m_data_reg    <= m_data_next;
        m_status_reg  <= m_status_next;
        m_occ_reg     <= m_occ_next;
        m_empty_reg   <= m_empty_next;
        m_full_reg    <= m_full_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign m_status     = m_status_reg;
    assign m_occupancy  = m_occ_reg;
    assign m_empty_flag = m_empty_reg;
    assign m_full_flag  = m_full_reg;

    // count never runs past the built depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    // a push that is not refused grows the stack by one
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        req_acc && s_kind == KIND_PUSH && !full_now
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the stack");

    // overflow is only reported on a full stack
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == ST_OVERFLOW |-> m_full_reg)
        else $error("overflow without full flag");

    // underflow is only reported on an empty stack
    a_unf_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == ST_UNDERFLOW |-> m_empty_reg)
        else $error("underflow without empty flag");

endmodule
